/* rtl/ssi_pkg.sv */
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared types and sizes for the sorted identifier set: request and response
// words, request and status codes, and the geometry of the cell row.
// ----------------------------------------------------------------------------
package ssi_pkg;

   // list geometry
   localparam int CAPACITY = 1024;
   localparam int ID_WIDTH = 20;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // cells are summarized in groups, then groups are summarized at the top
   localparam int GRP_SIZE = 32;
   localparam int GRP_W    = $clog2(GRP_SIZE);
   localparam int NUM_GRP  = CAPACITY / GRP_SIZE;
   localparam int NGRP_W   = IDX_W - GRP_W;

   // request codes
   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_CLEAR  = 2'd1,
      REQ_READ   = 2'd2,
      REQ_NONE   = 2'd3
   } ssi_req_code_type;

   // status codes
   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_DUP   = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } ssi_status_type;

   // request word
   typedef struct packed {
      ssi_req_code_type req_type;
      logic [19:0]      value;
      logic [9:0]       index;
   } ssi_req_type;

   // response word
   typedef struct packed {
      ssi_status_type status;
      logic [10:0]    entry_count;
      logic [9:0]     slot;
      logic [19:0]    read_value;
   } ssi_rsp_type;

   // summary of one group of cells
   typedef struct packed {
      logic                any_mark;
      logic                any_eq;
      logic [GRP_W-1:0]    pos;
      logic [ID_WIDTH-1:0] rd_value;
   } ssi_grp_type;

endpackage

/* rtl/ssi_cell.sv */
// ----------------------------------------------------------------------------
// ssi_cell
// One position of the sorted list: holds an entry, compares it with the
// broadcast value and, on insert, takes the new value or its left neighbor.
// ----------------------------------------------------------------------------
module ssi_cell
   import ssi_pkg::*;
(
   input  logic                clock,
   input  logic [ID_WIDTH-1:0] value,
   input  logic                used,
   input  logic                shift_en,
   input  logic                lt_left,
   input  logic [ID_WIDTH-1:0] entry_left,
   output logic [ID_WIDTH-1:0] entry,
   output logic                lt,
   output logic                eq
);

   logic [ID_WIDTH-1:0] entry_ff, entry_in;
   logic                lt_ff, lt_in;
   logic                eq_ff, eq_in;

   // compare flags and shift update
   always_comb begin
      lt_in    = used && (entry_ff < value);
      eq_in    = used && (entry_ff == value);
      entry_in = entry_ff;
      if (shift_en && !lt_ff) begin
         // first cell not below the value takes the value, later cells shift up
         entry_in = lt_left ? value : entry_left;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

/* rtl/ssi_group.sv */
// ----------------------------------------------------------------------------
// ssi_group
// Registered summary of one group of cells: match and boundary flags, the
// local position of the boundary and the entry picked for a read.
// ----------------------------------------------------------------------------
module ssi_group
   import ssi_pkg::*;
(
   input  logic                               clock,
   input  logic [GRP_SIZE-1:0]                mark,
   input  logic [GRP_SIZE-1:0]                eq,
   input  logic [GRP_SIZE-1:0][ID_WIDTH-1:0]  entries,
   input  logic [GRP_W-1:0]                   rd_sel,
   output ssi_grp_type                        summary
);

   ssi_grp_type grp_ff, grp_in;

   // at most one mark per row, so an or of indexes encodes it
   always_comb begin
      grp_in          = '0;
      grp_in.any_mark = |mark;
      grp_in.any_eq   = |eq;
      for (int k = 0; k < GRP_SIZE; k++) begin
         if (mark[k]) begin
            grp_in.pos = grp_in.pos | GRP_W'(k);
         end
      end
      grp_in.rd_value = entries[rd_sel];
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   assign summary = grp_ff;

endmodule

/* rtl/sorted_set_insert.sv */
// ----------------------------------------------------------------------------
// sorted_set_insert
// Ascending list of distinct identifiers kept in a row of compare-and-shift
// cells, with insert, clear and indexed read requests.
// ----------------------------------------------------------------------------
//
//   channel   ports                     handshake
//   --------  ------------------------  -------------------------------------
//   request   req_data                  taken when start is high, busy low
//   response  rsp_data                  valid for the one cycle of rsp_strobe
//
// After acceptance a request passes the cell compare, group summary, top
// summary, then update and response register before its response strobe
// rises. The response is taken at the edge that ends the strobe cycle. The
// two registered summary levels over the cell row sit in this path.
// busy is high from acceptance until the response shows; a new word may be
// started in the cycle the response strobe is high.
// Reset clears the entry count and the sequencer; no clearing pass is needed.
// The receiver cannot stall, so responses are never held back.
// ----------------------------------------------------------------------------
module sorted_set_insert
   import ssi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  ssi_req_type req_data,
   output logic        rsp_strobe,
   output ssi_rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CMP,
      S_GRP,
      S_TOP,
      S_EXEC
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   ssi_req_type         req_ff, req_in;
   ssi_rsp_type         rsp_ff, rsp_in;
   logic                strobe_ff, strobe_in;
   logic                shift_en;

   logic [CAPACITY-1:0]               used;
   logic [CAPACITY-1:0]               lt_q;
   logic [CAPACITY-1:0]               eq_q;
   logic [CAPACITY-1:0]               mark;
   logic [CAPACITY-1:0][ID_WIDTH-1:0] entry_q;
   ssi_grp_type                       grp_q [NUM_GRP];

   logic                top_dup_ff, top_dup_in;
   logic [IDX_W-1:0]    top_pos_ff, top_pos_in;
   logic [ID_WIDTH-1:0] top_rd_ff, top_rd_in;

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                lt_left;
      logic [ID_WIDTH-1:0] entry_left;
      if (i == 0) begin : g_first
         assign lt_left    = 1'b1;
         assign entry_left = '0;
      end else begin : g_rest
         assign lt_left    = lt_q[i-1];
         assign entry_left = entry_q[i-1];
      end
      assign used[i] = CNT_W'(i) < count_ff;
      // boundary: first position not below the value
      assign mark[i] = !lt_q[i] && lt_left;

      ssi_cell u_cell (
         .clock      (clock),
         .value      (req_ff.value[ID_WIDTH-1:0]),
         .used       (used[i]),
         .shift_en   (shift_en),
         .lt_left    (lt_left),
         .entry_left (entry_left),
         .entry      (entry_q[i]),
         .lt         (lt_q[i]),
         .eq         (eq_q[i])
      );
   end

   // group summaries
   for (genvar g = 0; g < NUM_GRP; g++) begin : g_group
      ssi_group u_group (
         .clock   (clock),
         .mark    (mark[g*GRP_SIZE +: GRP_SIZE]),
         .eq      (eq_q[g*GRP_SIZE +: GRP_SIZE]),
         .entries (entry_q[g*GRP_SIZE +: GRP_SIZE]),
         .rd_sel  (req_ff.index[GRP_W-1:0]),
         .summary (grp_q[g])
      );
   end

   // top summary over the groups
   always_comb begin
      top_dup_in = 1'b0;
      top_pos_in = '0;
      for (int g = 0; g < NUM_GRP; g++) begin
         top_dup_in = top_dup_in | grp_q[g].any_eq;
         if (grp_q[g].any_mark) begin
            top_pos_in = top_pos_in | {NGRP_W'(g), grp_q[g].pos};
         end
      end
      top_rd_in = grp_q[req_ff.index[IDX_W-1:GRP_W]].rd_value;
   end

   always_ff @(posedge clock) begin
      top_dup_ff <= top_dup_in;
      top_pos_ff <= top_pos_in;
      top_rd_ff  <= top_rd_in;
   end

   // sequencer next state and response
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      req_in    = req_ff;
      rsp_in    = '0;
      strobe_in = 1'b0;
      shift_en  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_GRP;
         end
         S_GRP: begin
            state_in = S_TOP;
         end
         S_TOP: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in  = S_IDLE;
            strobe_in = 1'b1;
            unique case (req_ff.req_type)
               REQ_INSERT: begin
                  priority if (top_dup_ff) begin
                     rsp_in.status = ST_DUP;
                     rsp_in.slot   = top_pos_ff;
                  end else if (count_ff == CNT_W'(CAPACITY)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     shift_en      = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                     rsp_in.status = ST_DONE;
                     rsp_in.slot   = top_pos_ff;
                  end
               end
               REQ_CLEAR: begin
                  count_in      = '0;
                  rsp_in.status = ST_DONE;
               end
               REQ_READ: begin
                  if (CNT_W'(req_ff.index) < count_ff) begin
                     rsp_in.status     = ST_DONE;
                     rsp_in.slot       = req_ff.index;
                     rsp_in.read_value = top_rd_ff;
                  end else begin
                     rsp_in.status = ST_RANGE;
                  end
               end
               default: begin
                  rsp_in.status = ST_DONE;
               end
            endcase
            rsp_in.entry_count = count_in;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
         req_ff    <= req_in;
         rsp_ff    <= rsp_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // every accepted word is answered by a response strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##5 rsp_strobe)
      else $error("response missing after accepted request");

   // the count only grows by one at a time
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (count_ff > $past(count_ff)) |->
         count_ff == $past(count_ff) + CNT_W'(1))
      else $error("entry count grew by more than one");

   // a duplicate is always found inside the held part of the list
   a_dup_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status == ST_DUP) |->
         CNT_W'(rsp_data.slot) < rsp_data.entry_count)
      else $error("duplicate reported outside the held entries");

endmodule
